[rtl/crdg_pkg.sv]
package crdg_pkg;

   localparam int FRAC_BITS = 16;
   localparam int COMP_W    = 21;
   localparam int OUT_W     = 18;
   localparam int IDX_W     = 12;
   localparam int SPAN_W    = 20;
   localparam int VEC_W     = 63;
   localparam int WIDE_W    = 44;
   localparam int PROD_W    = 2 * COMP_W;
   localparam int SQR_W     = 2 * COMP_W - 1;
   localparam int SUM_W     = SQR_W + 1;
   localparam int ROOT_W    = SUM_W / 2;
   localparam int SQ_STAGES = ROOT_W;
   localparam int QUO_W     = FRAC_BITS + 1;
   localparam int REM_W     = COMP_W + QUO_W;
   localparam int OFS_W     = IDX_W + SPAN_W;

   localparam logic signed [WIDE_W-1:0] COMP_HI = WIDE_W'(2 ** (COMP_W - 1) - 1);
   localparam logic signed [WIDE_W-1:0] COMP_LO = -WIDE_W'(2 ** (COMP_W - 1));

   localparam logic [2:0] REG_POSITION  = 3'd0;
   localparam logic [2:0] REG_VIEW_DIR  = 3'd1;
   localparam logic [2:0] REG_UP_HINT   = 3'd2;
   localparam logic [2:0] REG_HALF_COL  = 3'd3;
   localparam logic [2:0] REG_HALF_ROW  = 3'd4;
   localparam logic [2:0] REG_STEP_COL  = 3'd5;
   localparam logic [2:0] REG_STEP_ROW  = 3'd6;

   typedef logic [COMP_W-1:0] comp_type;
   typedef comp_type vec_type [3];

   typedef struct packed {
      logic             valid;
      logic             basis;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
   } meta_type;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_MUL,
      SEQ_SUM,
      SEQ_ISSUE,
      SEQ_WAIT
   } seq_state_type;

   function automatic logic [WIDE_W-1:0] wide_of(input comp_type c);
      return {{(WIDE_W - COMP_W){c[COMP_W-1]}}, c};
   endfunction

   // divide by 2^FRAC_BITS, round half away from zero
   function automatic logic [WIDE_W-1:0] rnd_shift(input logic [WIDE_W-1:0] v);
      logic [WIDE_W-1:0] m;
      logic [WIDE_W-1:0] r;
      m = v[WIDE_W-1] ? (~v + 1'b1) : v;
      r = (m + (WIDE_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
      return v[WIDE_W-1] ? (~r + 1'b1) : r;
   endfunction

   function automatic comp_type sat_comp(input logic [WIDE_W-1:0] v);
      comp_type r;
      if ($signed(v) > COMP_HI) begin
         r = COMP_HI[COMP_W-1:0];
      end else if ($signed(v) < COMP_LO) begin
         r = COMP_LO[COMP_W-1:0];
      end else begin
         r = v[COMP_W-1:0];
      end
      return r;
   endfunction

endpackage

[rtl/camera_ray_direction_gen_unit.sv]
// Channel   Ports                              Handshake
// request   start, busy, req_row, req_col      taken when start & !busy
// result    rsp_valid, rsp_out_*, rsp_dir_*,   one cycle per result, no backpressure
//           rsp_degenerate
// csr       psel, penable, pwrite, paddr,      APB, 64-bit data, register i at 8*i
//           pwdata, prdata, pready
//
// One request per cycle while busy is low; each result passes through the 21-stage square root
// and the 17-stage divider of the normalize pipeline.
// A write to view_dir or up_hint recomputes the right/up basis through the same
// normalize pipeline; busy is high meanwhile.
// Synchronous reset clears the pipeline valids, the sequencer, the basis and all configuration registers.
// The receiver cannot stall; the pipeline never holds.
module camera_ray_direction_gen_unit #(
   parameter int MAX_DIM = 4096
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [crdg_pkg::IDX_W-1:0]           req_row,
   input  logic [crdg_pkg::IDX_W-1:0]           req_col,
   output logic                                 rsp_valid,
   output logic [crdg_pkg::IDX_W-1:0]           rsp_out_row,
   output logic [crdg_pkg::IDX_W-1:0]           rsp_out_col,
   output logic signed [crdg_pkg::OUT_W-1:0]    rsp_dir_x,
   output logic signed [crdg_pkg::OUT_W-1:0]    rsp_dir_y,
   output logic signed [crdg_pkg::OUT_W-1:0]    rsp_dir_z,
   output logic                                 rsp_degenerate,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [5:0]                           paddr,
   input  logic [63:0]                          pwdata,
   output logic [63:0]                          prdata,
   output logic                                 pready
);

   localparam int IW   = crdg_pkg::IDX_W;
   localparam int CW   = crdg_pkg::COMP_W;
   localparam int WW   = crdg_pkg::WIDE_W;
   localparam int SW   = crdg_pkg::SUM_W;
   localparam int RW   = crdg_pkg::ROOT_W;
   localparam int NSQ  = crdg_pkg::SQ_STAGES;
   localparam int QW   = crdg_pkg::QUO_W;
   localparam int MW   = crdg_pkg::REM_W;
   localparam int OW   = crdg_pkg::OUT_W;
   localparam int FB   = crdg_pkg::FRAC_BITS;
   localparam int LATENCY = 5 + (NSQ + 1) + (QW + 1) + 1;
   localparam logic [IW-1:0] IDX_CLAMP =
      (MAX_DIM >= 2 ** IW) ? {IW{1'b1}} : IW'(MAX_DIM - 1);
   localparam logic [OW-1:0] UNIT_ONE = OW'(2 ** FB);

   // ---------------- configuration ----------------
   logic [crdg_pkg::VEC_W-1:0]  pos_ff, dir_ff, hint_ff;
   logic [crdg_pkg::SPAN_W-1:0] half_col_ff, half_row_ff, step_col_ff, step_row_ff;
   logic        csr_wr;
   logic [2:0]  csr_idx;
   logic        basis_trig;

   assign pready     = 1'b1;
   assign csr_wr     = psel & penable & pwrite;
   assign csr_idx    = paddr[5:3];
   assign basis_trig = csr_wr &
      ((csr_idx == crdg_pkg::REG_VIEW_DIR) || (csr_idx == crdg_pkg::REG_UP_HINT));

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         dir_ff      <= '0;
         hint_ff     <= '0;
         half_col_ff <= '0;
         half_row_ff <= '0;
         step_col_ff <= '0;
         step_row_ff <= '0;
      end else if (csr_wr) begin
         case (csr_idx)
            crdg_pkg::REG_POSITION: pos_ff      <= pwdata[crdg_pkg::VEC_W-1:0];
            crdg_pkg::REG_VIEW_DIR: dir_ff      <= pwdata[crdg_pkg::VEC_W-1:0];
            crdg_pkg::REG_UP_HINT:  hint_ff     <= pwdata[crdg_pkg::VEC_W-1:0];
            crdg_pkg::REG_HALF_COL: half_col_ff <= pwdata[crdg_pkg::SPAN_W-1:0];
            crdg_pkg::REG_HALF_ROW: half_row_ff <= pwdata[crdg_pkg::SPAN_W-1:0];
            crdg_pkg::REG_STEP_COL: step_col_ff <= pwdata[crdg_pkg::SPAN_W-1:0];
            crdg_pkg::REG_STEP_ROW: step_row_ff <= pwdata[crdg_pkg::SPAN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         crdg_pkg::REG_POSITION: prdata = 64'(pos_ff);
         crdg_pkg::REG_VIEW_DIR: prdata = 64'(dir_ff);
         crdg_pkg::REG_UP_HINT:  prdata = 64'(hint_ff);
         crdg_pkg::REG_HALF_COL: prdata = 64'(half_col_ff);
         crdg_pkg::REG_HALF_ROW: prdata = 64'(half_row_ff);
         crdg_pkg::REG_STEP_COL: prdata = 64'(step_col_ff);
         crdg_pkg::REG_STEP_ROW: prdata = 64'(step_row_ff);
         default:                prdata = '0;
      endcase
   end

   crdg_pkg::vec_type dir_v, hint_v;
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dir_v[i]  = dir_ff[CW*i +: CW];
         hint_v[i] = hint_ff[CW*i +: CW];
      end
   end

   // ---------------- basis sequencer ----------------
   crdg_pkg::seq_state_type seq_ff, seq_in;
   logic pass_ff, pass_in, redo_ff, redo_in;
   logic seq_busy, cr_mul_en, cr_sum_en, inject, start_run, basis_exit;
   crdg_pkg::vec_type right_ff, up_ff;
   logic right_ok_ff, up_ok_ff;

   crdg_pkg::meta_type fin_meta_ff;
   logic               fin_zero_ff;
   logic [OW-1:0]      fin_unit_ff [3];

   assign basis_exit = fin_meta_ff.valid & fin_meta_ff.basis;

   always_comb begin
      seq_busy  = (seq_ff != crdg_pkg::SEQ_IDLE) | redo_ff;
      cr_mul_en = (seq_ff == crdg_pkg::SEQ_MUL);
      cr_sum_en = (seq_ff == crdg_pkg::SEQ_SUM);
      inject    = (seq_ff == crdg_pkg::SEQ_ISSUE);
      start_run = ((seq_ff == crdg_pkg::SEQ_IDLE) & (basis_trig | redo_ff)) |
                  ((seq_ff == crdg_pkg::SEQ_WAIT) & basis_exit & pass_ff & redo_ff);
   end

   always_comb begin
      case (seq_ff)
         crdg_pkg::SEQ_IDLE:  seq_in = start_run ? crdg_pkg::SEQ_MUL : crdg_pkg::SEQ_IDLE;
         crdg_pkg::SEQ_MUL:   seq_in = crdg_pkg::SEQ_SUM;
         crdg_pkg::SEQ_SUM:   seq_in = crdg_pkg::SEQ_ISSUE;
         crdg_pkg::SEQ_ISSUE: seq_in = crdg_pkg::SEQ_WAIT;
         crdg_pkg::SEQ_WAIT: begin
            if (!basis_exit) begin
               seq_in = crdg_pkg::SEQ_WAIT;
            end else if (!pass_ff || start_run) begin
               seq_in = crdg_pkg::SEQ_MUL;
            end else begin
               seq_in = crdg_pkg::SEQ_IDLE;
            end
         end
         default:             seq_in = crdg_pkg::SEQ_IDLE;
      endcase
      redo_in = start_run ? 1'b0 : (redo_ff | basis_trig);
      if (start_run) begin
         pass_in = 1'b0;
      end else if ((seq_ff == crdg_pkg::SEQ_WAIT) && basis_exit && !pass_ff) begin
         pass_in = 1'b1;
      end else begin
         pass_in = pass_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff      <= crdg_pkg::SEQ_IDLE;
         pass_ff     <= 1'b0;
         redo_ff     <= 1'b0;
         right_ok_ff <= 1'b0;
         up_ok_ff    <= 1'b0;
         right_ff    <= '{default: '0};
         up_ff       <= '{default: '0};
      end else begin
         seq_ff  <= seq_in;
         pass_ff <= pass_in;
         redo_ff <= redo_in;
         if ((seq_ff == crdg_pkg::SEQ_WAIT) && basis_exit) begin
            for (int i = 0; i < 3; i++) begin
               if (!pass_ff) begin
                  right_ff[i] <= CW'($signed(fin_unit_ff[i]));
               end else begin
                  up_ff[i] <= CW'($signed(fin_unit_ff[i]));
               end
            end
            if (!pass_ff) begin
               right_ok_ff <= !fin_zero_ff;
            end else begin
               up_ok_ff <= !fin_zero_ff;
            end
         end
      end
   end

   assign busy = seq_busy;

   // shared cross product: pass 0 dir x hint, pass 1 right x dir
   crdg_pkg::vec_type cr_a, cr_b, cross_ff;
   logic [WW-1:0] cr_pa_ff [3];
   logic [WW-1:0] cr_pb_ff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         cr_a[i] = pass_ff ? right_ff[i] : dir_v[i];
         cr_b[i] = pass_ff ? dir_v[i]    : hint_v[i];
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         if (cr_mul_en) begin
            cr_pa_ff[i] <= WW'($signed(cr_a[(i + 1) % 3]) * $signed(cr_b[(i + 2) % 3]));
            cr_pb_ff[i] <= WW'($signed(cr_a[(i + 2) % 3]) * $signed(cr_b[(i + 1) % 3]));
         end
         if (cr_sum_en) begin
            cross_ff[i] <= crdg_pkg::sat_comp(crdg_pkg::rnd_shift(cr_pa_ff[i] - cr_pb_ff[i]));
         end
      end
   end

   // ---------------- pixel front end ----------------
   crdg_pkg::meta_type p0_meta_ff, p1_meta_ff, p2_meta_ff, ne_meta_ff, sqr_meta_ff;
   logic [crdg_pkg::OFS_W-1:0] p0_mc_ff, p0_mr_ff;
   crdg_pkg::comp_type p1_co_ff, p1_ro_ff;
   logic [WW-1:0] p2_pr_ff [3];
   logic [WW-1:0] p2_pu_ff [3];
   crdg_pkg::vec_type ne_vec_ff, sqr_vec_ff, ne_pix;
   logic [crdg_pkg::SQR_W-1:0] sqr_sq_ff [3];
   logic [IW-1:0] row_c, col_c;
   logic [crdg_pkg::PROD_W-1:0] sq_full [3];

   assign row_c = (req_row > IDX_CLAMP) ? IDX_CLAMP : req_row;
   assign col_c = (req_col > IDX_CLAMP) ? IDX_CLAMP : req_col;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         ne_pix[i] = crdg_pkg::sat_comp(crdg_pkg::wide_of(dir_v[i]) +
                     crdg_pkg::rnd_shift(p2_pr_ff[i]) + crdg_pkg::rnd_shift(p2_pu_ff[i]));
         sq_full[i] = crdg_pkg::PROD_W'($signed(ne_vec_ff[i]) * $signed(ne_vec_ff[i]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p0_meta_ff  <= '0;
         p1_meta_ff  <= '0;
         p2_meta_ff  <= '0;
         ne_meta_ff  <= '0;
         sqr_meta_ff <= '0;
      end else begin
         p0_meta_ff <= '{valid: start & !seq_busy, basis: 1'b0, row: req_row, col: req_col};
         p1_meta_ff <= p0_meta_ff;
         p2_meta_ff <= p1_meta_ff;
         if (inject) begin
            ne_meta_ff <= '{valid: 1'b1, basis: 1'b1, row: '0, col: '0};
         end else begin
            ne_meta_ff <= p2_meta_ff;
         end
         sqr_meta_ff <= ne_meta_ff;
      end
   end

   always_ff @(posedge clock) begin
      p0_mc_ff <= crdg_pkg::OFS_W'(col_c) * crdg_pkg::OFS_W'(step_col_ff);
      p0_mr_ff <= crdg_pkg::OFS_W'(row_c) * crdg_pkg::OFS_W'(step_row_ff);
      p1_co_ff <= crdg_pkg::sat_comp(WW'(p0_mc_ff) - WW'(half_col_ff));
      p1_ro_ff <= crdg_pkg::sat_comp(WW'(p0_mr_ff) - WW'(half_row_ff));
      for (int i = 0; i < 3; i++) begin
         p2_pr_ff[i]  <= WW'($signed(right_ff[i]) * $signed(p1_co_ff));
         p2_pu_ff[i]  <= WW'($signed(up_ff[i]) * $signed(p1_ro_ff));
         ne_vec_ff[i] <= inject ? cross_ff[i] : ne_pix[i];
         sqr_sq_ff[i] <= sq_full[i][crdg_pkg::SQR_W-1:0];
      end
      sqr_vec_ff <= ne_vec_ff;
   end

   // ---------------- square root, one result bit per stage ----------------
   crdg_pkg::meta_type sq_meta_ff [NSQ+1];
   crdg_pkg::meta_type sq_meta_in [NSQ+1];
   crdg_pkg::vec_type  sq_vec_ff  [NSQ+1];
   crdg_pkg::vec_type  sq_vec_in  [NSQ+1];
   logic [SW-1:0]      sq_x_ff    [NSQ+1];
   logic [SW-1:0]      sq_x_in    [NSQ+1];
   logic [SW-1:0]      sq_res_ff  [NSQ+1];
   logic [SW-1:0]      sq_res_in  [NSQ+1];
   logic               sq_zero_ff [NSQ+1];
   logic               sq_zero_in [NSQ+1];

   always_comb begin
      logic [SW-1:0] sbit;
      logic [SW-1:0] trial;
      sq_meta_in[0] = sqr_meta_ff;
      sq_vec_in[0]  = sqr_vec_ff;
      sq_x_in[0]    = SW'(sqr_sq_ff[0]) + SW'(sqr_sq_ff[1]) + SW'(sqr_sq_ff[2]);
      sq_res_in[0]  = '0;
      sq_zero_in[0] = (sq_x_in[0] == '0);
      for (int s = 0; s < NSQ; s++) begin
         sbit  = SW'(1) << (2 * (NSQ - 1 - s));
         trial = sq_res_ff[s] + sbit;
         sq_meta_in[s+1] = sq_meta_ff[s];
         sq_vec_in[s+1]  = sq_vec_ff[s];
         sq_zero_in[s+1] = sq_zero_ff[s];
         if (sq_x_ff[s] >= trial) begin
            sq_x_in[s+1]   = sq_x_ff[s] - trial;
            sq_res_in[s+1] = (sq_res_ff[s] >> 1) + sbit;
         end else begin
            sq_x_in[s+1]   = sq_x_ff[s];
            sq_res_in[s+1] = sq_res_ff[s] >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s <= NSQ; s++) begin
         if (reset) begin
            sq_meta_ff[s] <= '0;
         end else begin
            sq_meta_ff[s] <= sq_meta_in[s];
         end
         sq_vec_ff[s]  <= sq_vec_in[s];
         sq_x_ff[s]    <= sq_x_in[s];
         sq_res_ff[s]  <= sq_res_in[s];
         sq_zero_ff[s] <= sq_zero_in[s];
      end
   end

   // ---------------- divide, one quotient bit per stage ----------------
   crdg_pkg::meta_type d_meta_ff [QW+1];
   crdg_pkg::meta_type d_meta_in [QW+1];
   logic [RW-1:0]      d_len_ff  [QW+1];
   logic [RW-1:0]      d_len_in  [QW+1];
   logic               d_zero_ff [QW+1];
   logic               d_zero_in [QW+1];
   logic [2:0]         d_neg_ff  [QW+1];
   logic [2:0]         d_neg_in  [QW+1];
   logic [MW-1:0]      d_rem_ff  [QW+1][3];
   logic [MW-1:0]      d_rem_in  [QW+1][3];
   logic [QW-1:0]      d_quo_ff  [QW+1][3];
   logic [QW-1:0]      d_quo_in  [QW+1][3];

   always_comb begin
      crdg_pkg::comp_type mag;
      logic [MW-1:0] dv;
      d_meta_in[0] = sq_meta_ff[NSQ];
      d_zero_in[0] = sq_zero_ff[NSQ];
      d_len_in[0]  = sq_res_ff[NSQ][RW-1:0];
      for (int i = 0; i < 3; i++) begin
         d_neg_in[0][i] = sq_vec_ff[NSQ][i][CW-1];
         mag = d_neg_in[0][i] ? (~sq_vec_ff[NSQ][i] + 1'b1) : sq_vec_ff[NSQ][i];
         // rounding term len/2 folded into the dividend
         d_rem_in[0][i] = (MW'(mag) << FB) + MW'(d_len_in[0] >> 1);
         d_quo_in[0][i] = '0;
      end
      for (int s = 0; s < QW; s++) begin
         d_meta_in[s+1] = d_meta_ff[s];
         d_zero_in[s+1] = d_zero_ff[s];
         d_len_in[s+1]  = d_len_ff[s];
         d_neg_in[s+1]  = d_neg_ff[s];
         dv = MW'(d_len_ff[s]) << (QW - 1 - s);
         for (int i = 0; i < 3; i++) begin
            if (d_rem_ff[s][i] >= dv) begin
               d_rem_in[s+1][i] = d_rem_ff[s][i] - dv;
               d_quo_in[s+1][i] = d_quo_ff[s][i] | (QW'(1) << (QW - 1 - s));
            end else begin
               d_rem_in[s+1][i] = d_rem_ff[s][i];
               d_quo_in[s+1][i] = d_quo_ff[s][i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s <= QW; s++) begin
         if (reset) begin
            d_meta_ff[s] <= '0;
         end else begin
            d_meta_ff[s] <= d_meta_in[s];
         end
         d_len_ff[s]  <= d_len_in[s];
         d_zero_ff[s] <= d_zero_in[s];
         d_neg_ff[s]  <= d_neg_in[s];
         for (int i = 0; i < 3; i++) begin
            d_rem_ff[s][i] <= d_rem_in[s][i];
            d_quo_ff[s][i] <= d_quo_in[s][i];
         end
      end
   end

   // ---------------- finish ----------------
   logic [OW-1:0] fin_unit_in [3];

   always_comb begin
      logic [OW-1:0] q;
      for (int i = 0; i < 3; i++) begin
         q = OW'(d_quo_ff[QW][i]);
         if (q > UNIT_ONE) begin
            q = UNIT_ONE;
         end
         if (d_zero_ff[QW]) begin
            fin_unit_in[i] = '0;
         end else begin
            fin_unit_in[i] = d_neg_ff[QW][i] ? (~q + 1'b1) : q;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_meta_ff <= '0;
      end else begin
         fin_meta_ff <= d_meta_ff[QW];
      end
      fin_zero_ff <= d_zero_ff[QW];
      for (int i = 0; i < 3; i++) begin
         fin_unit_ff[i] <= fin_unit_in[i];
      end
   end

   logic fin_ok;
   assign fin_ok         = !fin_zero_ff & right_ok_ff & up_ok_ff;
   assign rsp_valid      = fin_meta_ff.valid & !fin_meta_ff.basis;
   assign rsp_out_row    = fin_meta_ff.row;
   assign rsp_out_col    = fin_meta_ff.col;
   assign rsp_dir_x      = fin_ok ? $signed(fin_unit_ff[0]) : '0;
   assign rsp_dir_y      = fin_ok ? $signed(fin_unit_ff[1]) : '0;
   assign rsp_dir_z      = fin_ok ? $signed(fin_unit_ff[2]) : '0;
   assign rsp_degenerate = !fin_ok;

`ifndef SYNTHESIS
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("request did not produce a result on time");

   a_basis_exit: assert property (@(posedge clock) disable iff (reset)
      basis_exit |-> (seq_ff == crdg_pkg::SEQ_WAIT))
      else $error("basis vector left the pipeline with no sequencer waiting");

   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_degenerate) |-> (rsp_dir_x == '0 && rsp_dir_y == '0 &&
                                         rsp_dir_z == '0))
      else $error("degenerate result with nonzero direction");

   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($signed(rsp_dir_x) <= $signed(UNIT_ONE) &&
                     $signed(rsp_dir_x) >= -$signed(UNIT_ONE)))
      else $error("direction component beyond unit range");
`endif

endmodule
